>>> rtl/polynomial_field_evaluator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the polynomial field evaluator
// Concurrent checks clocked on clk; one form masked by rst, one always live.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_FIELD_EVALUATOR_ASSERT_SVH
`define POLYNOMIAL_FIELD_EVALUATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked outside reset
`define PFE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("pfe assertion failed");

// Checked during reset too
`define PFE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("pfe assertion failed");

`else

`define PFE_ASSERT(lbl, prop)
`define PFE_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

>>> rtl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types, codes and defaults of the polynomial field evaluator.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int MAX_DEGREE_DEF = 7;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic CMD_EVAL = 1'b0;
  localparam logic CMD_COEF = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] u_coord;
    logic signed [31:0] v_coord;
    logic [5:0]         coef_index;
    logic signed [31:0] coef_value;
  } item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [16:0]        blend_weight;
  } result_t;

  typedef enum logic [2:0] {
    MODE_BUMP   = 3'd0,
    MODE_MONO   = 3'd1,
    MODE_PARA   = 3'd2,
    MODE_SADDLE = 3'd3,
    MODE_MONKEY = 3'd4,
    MODE_BIVAR  = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_CENTER_U  = 3'd1,
    REG_CENTER_V  = 3'd2,
    REG_INV_SCL_U = 3'd3,
    REG_INV_SCL_V = 3'd4,
    REG_AMPLITUDE = 3'd5,
    REG_DEGREE    = 3'd6,
    REG_MONO_EXP  = 3'd7
  } reg_t;

  // Datapath operations, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CENTRE,
    OP_SCALE_X,
    OP_SCALE_Y,
    OP_SQ_X,
    OP_SQ_Y,
    OP_ADD_SR,
    OP_SUB_SR,
    OP_ONE_MINUS_R,
    OP_P_ONE,
    OP_P_MUL_R,
    OP_P_MUL_X,
    OP_P_MUL_Y,
    OP_S_AMP_P,
    OP_S_MUL_X,
    OP_R_3X,
    OP_R_MUL_Y,
    OP_S_CF_P,
    OP_S_MUL_P,
    OP_ACC_CLR,
    OP_COEF_READ,
    OP_ACC_ADD,
    OP_VAL_AMP_P,
    OP_VAL_AMP_R,
    OP_VAL_S_P,
    OP_VAL_AMP_ACC,
    OP_VAL_ZERO,
    OP_DIV_INIT,
    OP_DIV_STEP
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CENTRE,
    ST_SCALE_X,
    ST_SCALE_Y,
    ST_SQ_X,
    ST_SQ_Y,
    ST_COMB,
    ST_BUMP_OMR,
    ST_BUMP_P1,
    ST_BUMP_PW,
    ST_MONO_P1X,
    ST_MONO_PX,
    ST_MONO_AMP,
    ST_MONO_P1Y,
    ST_MONO_PY,
    ST_MK_XX,
    ST_MK_XXX,
    ST_MK_3X,
    ST_MK_RY1,
    ST_MK_RY2,
    ST_MK_SUB,
    ST_BV_CLR,
    ST_BV_READ,
    ST_BV_P1X,
    ST_BV_PX,
    ST_BV_CF,
    ST_BV_P1Y,
    ST_BV_PY,
    ST_BV_SP,
    ST_BV_ACC,
    ST_VAL,
    ST_DIV
  } state_t;

  // Extra states kept apart to stay within 5 bits
  typedef enum logic [1:0] {
    SUB_NONE,
    SUB_ZERO,
    SUB_DIV_INIT,
    SUB_DONE
  } sub_t;

  typedef struct packed {
    mode_t      mode;
    logic [2:0] degree;
    logic [2:0] px;
    logic [2:0] py;
    logic       r_pos;
    logic       div_skip;
  } status_t;

endpackage

>>> rtl/polynomial_field_evaluator.sv
// ----------------------------------------------------------------------------
// polynomial_field_evaluator
// Evaluates a 2D polynomial field at (u,v) in signed fixed point, with a
// blend weight; also loads the coefficient triangle of the bivariate mode.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     start & !busy          item   (cmd, u/v, coef index/value)
//  result    done, one cycle        result (value, blend_weight)
//  config    cfg_we                 cfg_index, cfg_data
//
// A coefficient write is stored when accepted and gives no result.
// An evaluation runs one operation per cycle through a single shared
// multiplier: centring and scaling, then the mode's chain (the bump's
// ends early outside the disc, the monomial's grows with px and py, the
// bivariate one runs term by term over the triangle, an undefined mode
// has none), a value step, a divider set-up step, FRAC_BITS quotient bits
// at one a cycle (skipped when the weight is 0 or saturates at one), and
// then the done strobe.
// Reset is synchronous; the coefficient store reads zero until written,
// with no clearing pass. The receiver cannot stall: done is a one-cycle
// strobe and the word must be taken then.
// ----------------------------------------------------------------------------
module polynomial_field_evaluator #(
  parameter int MAX_DEGREE = pfe_pkg::MAX_DEGREE_DEF,
  parameter int FRAC_BITS  = pfe_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  pfe_pkg::item_t   item,
  output logic             done,
  output pfe_pkg::result_t result,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);
  import pfe_pkg::*;

  logic    accept;
  logic    accept_eval;
  op_t     op;
  status_t status;

  // one word taken whenever the sequencer is idle
  assign accept      = start && !busy;
  assign accept_eval = accept && (item.cmd == CMD_EVAL);

  pfe_ctrl #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept_eval (accept_eval),
    .status      (status),
    .op          (op),
    .busy        (busy),
    .done        (done)
  );

  pfe_dp #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op        (op),
    .status    (status),
    .result    (result)
  );

endmodule

>>> rtl/pfe_dp.sv
// ----------------------------------------------------------------------------
// pfe_dp
// Datapath: configuration registers, coefficient store, shared multiplier,
// saturating adder and a one-bit-per-cycle divider for the blend weight.
// ----------------------------------------------------------------------------
module pfe_dp #(
  parameter int MAX_DEGREE = 7,
  parameter int FRAC_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  pfe_pkg::item_t    item,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  pfe_pkg::op_t      op,
  output pfe_pkg::status_t  status,
  output pfe_pkg::result_t  result
);
  import pfe_pkg::*;

  localparam int DEPTH = (MAX_DEGREE + 1) * (MAX_DEGREE + 2) / 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = (AW > 6) ? AW : 6;
  localparam logic signed [31:0] ONE   = 32'sd1 <<< FRAC_BITS;
  localparam logic [FRAC_BITS:0] ONE_W = {1'b1, {FRAC_BITS{1'b0}}};

  function automatic logic signed [31:0] sat(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // configuration
  mode_t              mode;
  logic signed [31:0] cu, cv, isu, isv, amp;
  logic [2:0]         degree;
  logic [5:0]         mexp;

  // working registers
  logic signed [31:0] x, y, r, s, p, acc, cf, val;
  logic [FRAC_BITS:0] w;
  logic [31:0]        rem;
  logic [AW-1:0]      k;

  logic signed [31:0] mem [DEPTH];
  logic [DEPTH-1:0]   vld;

  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [31:0] mres;
  logic [31:0]        mag;
  logic [32:0]        rem2;
  logic [IW-1:0]      widx;

  always_comb begin
    ma = x;
    mb = x;
    case (op)
      OP_SCALE_X:     begin ma = x;   mb = isu; end
      OP_SCALE_Y:     begin ma = y;   mb = isv; end
      OP_SQ_X:        begin ma = x;   mb = x;   end
      OP_SQ_Y:        begin ma = y;   mb = y;   end
      OP_P_MUL_R:     begin ma = p;   mb = r;   end
      OP_P_MUL_X:     begin ma = p;   mb = x;   end
      OP_P_MUL_Y:     begin ma = p;   mb = y;   end
      OP_S_AMP_P:     begin ma = amp; mb = p;   end
      OP_S_MUL_X:     begin ma = s;   mb = x;   end
      OP_R_MUL_Y:     begin ma = r;   mb = y;   end
      OP_S_CF_P:      begin ma = cf;  mb = p;   end
      OP_S_MUL_P:     begin ma = s;   mb = p;   end
      OP_VAL_AMP_P:   begin ma = amp; mb = p;   end
      OP_VAL_AMP_R:   begin ma = amp; mb = r;   end
      OP_VAL_S_P:     begin ma = s;   mb = p;   end
      OP_VAL_AMP_ACC: begin ma = amp; mb = acc; end
      default:        begin ma = x;   mb = x;   end
    endcase
  end

  // arithmetic shift floors, as the product rounding requires
  assign prod = ma * mb;
  assign mres = sat(prod >>> FRAC_BITS);

  assign mag  = amp[31] ? (~amp + 32'd1) : amp;
  assign rem2 = {rem, 1'b0};
  assign widx = IW'(item.coef_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_BUMP;
      cu     <= '0;
      cv     <= '0;
      isu    <= ONE;
      isv    <= ONE;
      amp    <= ONE;
      degree <= 3'd2;
      mexp   <= '0;
    end else if (cfg_we) begin
      case (reg_t'(cfg_index))
        REG_MODE:      mode   <= mode_t'(cfg_data[2:0]);
        REG_CENTER_U:  cu     <= cfg_data;
        REG_CENTER_V:  cv     <= cfg_data;
        REG_INV_SCL_U: isu    <= cfg_data;
        REG_INV_SCL_V: isv    <= cfg_data;
        REG_AMPLITUDE: amp    <= cfg_data;
        REG_DEGREE:    degree <= cfg_data[2:0];
        REG_MONO_EXP:  mexp   <= cfg_data[5:0];
        default:       mode   <= mode;
      endcase
    end
  end

  // coefficient store; valid bits stand in for the clear at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (accept && item.cmd == CMD_COEF && widx < IW'(DEPTH)) begin
      vld[widx[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.cmd == CMD_COEF && widx < IW'(DEPTH)) begin
      mem[widx[AW-1:0]] <= item.coef_value;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_COEF_READ) begin
      cf <= vld[k] ? mem[k] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.cmd == CMD_EVAL) begin
      x <= item.u_coord;
      y <= item.v_coord;
    end else begin
      case (op)
        OP_CENTRE: begin
          x <= sat(64'(x) - 64'(cu));
          y <= sat(64'(y) - 64'(cv));
        end
        OP_SCALE_X:     x   <= mres;
        OP_SCALE_Y:     y   <= mres;
        OP_SQ_X:        s   <= mres;
        OP_SQ_Y:        r   <= mres;
        OP_ADD_SR:      r   <= sat(64'(s) + 64'(r));
        OP_SUB_SR:      r   <= sat(64'(s) - 64'(r));
        OP_ONE_MINUS_R: r   <= sat(64'(ONE) - 64'(r));
        OP_P_ONE:       p   <= ONE;
        OP_P_MUL_R:     p   <= mres;
        OP_P_MUL_X:     p   <= mres;
        OP_P_MUL_Y:     p   <= mres;
        OP_S_AMP_P:     s   <= mres;
        OP_S_MUL_X:     s   <= mres;
        OP_R_3X:        r   <= sat(64'(x) + 64'(x) + 64'(x));
        OP_R_MUL_Y:     r   <= mres;
        OP_S_CF_P:      s   <= mres;
        OP_S_MUL_P:     s   <= mres;
        OP_ACC_CLR: begin
          acc <= '0;
          k   <= '0;
        end
        OP_ACC_ADD: begin
          acc <= sat(64'(acc) + 64'(s));
          k   <= k + AW'(1);
        end
        OP_VAL_AMP_P:   val <= mres;
        OP_VAL_AMP_R:   val <= mres;
        OP_VAL_S_P:     val <= mres;
        OP_VAL_AMP_ACC: val <= mres;
        OP_VAL_ZERO:    val <= '0;
        OP_DIV_INIT: begin
          rem <= val;
          w   <= (status.div_skip && mag != '0 && val > 0) ? ONE_W : '0;
        end
        OP_DIV_STEP: begin
          if (rem2 >= {1'b0, mag}) begin
            rem <= 32'(rem2 - {1'b0, mag});
            w   <= {w[FRAC_BITS-1:0], 1'b1};
          end else begin
            rem <= rem2[31:0];
            w   <= {w[FRAC_BITS-1:0], 1'b0};
          end
        end
        default: x <= x;
      endcase
    end
  end

  always_comb begin
    status.mode     = mode;
    status.degree   = degree;
    status.px       = mexp[2:0];
    status.py       = mexp[5:3];
    status.r_pos    = (r > 0);
    // no division needed: weight is zero, or value at least |amplitude|
    status.div_skip = (mag == '0) || (val <= 0) || (32'(val) >= mag);
  end

  assign result.value        = val;
  assign result.blend_weight = 17'(w);

endmodule

>>> rtl/pfe_ctrl.sv
// ----------------------------------------------------------------------------
// pfe_ctrl
// Sequencer: walks each mode's chain of datapath operations, counts power
// loops, the coefficient triangle and the divider steps.
// ----------------------------------------------------------------------------
module pfe_ctrl #(
  parameter int MAX_DEGREE = 7,
  parameter int FRAC_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept_eval,
  input  pfe_pkg::status_t  status,
  output pfe_pkg::op_t      op,
  output logic              busy,
  output logic              done
);
  import pfe_pkg::*;

  `include "polynomial_field_evaluator_assert.svh"

  localparam int TDW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE + 1) : 1;
  localparam int FCW = $clog2(FRAC_BITS + 1);
  localparam int CW  = (FCW > TDW) ? ((FCW > 3) ? FCW : 3) : ((TDW > 3) ? TDW : 3);

  state_t           state, state_next;
  sub_t             sub, sub_next;
  logic [CW-1:0]    cnt, cnt_next;
  logic [TDW-1:0]   td, td_next, ti, ti_next;
  logic [TDW-1:0]   lim;

  assign lim = (int'(status.degree) > MAX_DEGREE) ? TDW'(MAX_DEGREE) : TDW'(status.degree);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sub   <= SUB_NONE;
      cnt   <= '0;
      td    <= '0;
      ti    <= '0;
    end else begin
      state <= state_next;
      sub   <= sub_next;
      cnt   <= cnt_next;
      td    <= td_next;
      ti    <= ti_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    sub_next   = SUB_NONE;
    cnt_next   = cnt;
    td_next    = td;
    ti_next    = ti;
    case (state)
      ST_IDLE:    if (accept_eval) state_next = ST_CENTRE;
      ST_CENTRE:  state_next = ST_SCALE_X;
      ST_SCALE_X: state_next = ST_SCALE_Y;
      ST_SCALE_Y: begin
        case (status.mode)
          MODE_BUMP, MODE_PARA, MODE_SADDLE: state_next = ST_SQ_X;
          MODE_MONO:   state_next = ST_MONO_P1X;
          MODE_MONKEY: state_next = ST_MK_XX;
          MODE_BIVAR:  state_next = ST_BV_CLR;
          default: begin
            state_next = ST_VAL;
            sub_next   = SUB_ZERO;
          end
        endcase
      end
      ST_SQ_X: state_next = ST_SQ_Y;
      ST_SQ_Y: state_next = ST_COMB;
      ST_COMB: state_next = (status.mode == MODE_BUMP) ? ST_BUMP_OMR : ST_VAL;
      ST_BUMP_OMR: state_next = ST_BUMP_P1;
      ST_BUMP_P1: begin
        cnt_next = CW'(status.degree);
        if (!status.r_pos) begin
          state_next = ST_VAL;
          sub_next   = SUB_ZERO;
        end else begin
          state_next = ST_BUMP_PW;
        end
      end
      ST_BUMP_PW, ST_MONO_PX, ST_MONO_PY, ST_BV_PX, ST_BV_PY: begin
        if (cnt == '0) begin
          case (state)
            ST_BUMP_PW: state_next = ST_VAL;
            ST_MONO_PX: state_next = ST_MONO_AMP;
            ST_MONO_PY: state_next = ST_VAL;
            ST_BV_PX:   state_next = ST_BV_CF;
            default:    state_next = ST_BV_SP;
          endcase
        end else begin
          cnt_next = cnt - CW'(1);
        end
      end
      ST_MONO_P1X: begin
        cnt_next   = CW'(status.px);
        state_next = ST_MONO_PX;
      end
      ST_MONO_AMP: state_next = ST_MONO_P1Y;
      ST_MONO_P1Y: begin
        cnt_next   = CW'(status.py);
        state_next = ST_MONO_PY;
      end
      ST_MK_XX:  state_next = ST_MK_XXX;
      ST_MK_XXX: state_next = ST_MK_3X;
      ST_MK_3X:  state_next = ST_MK_RY1;
      ST_MK_RY1: state_next = ST_MK_RY2;
      ST_MK_RY2: state_next = ST_MK_SUB;
      ST_MK_SUB: state_next = ST_VAL;
      ST_BV_CLR: begin
        td_next    = '0;
        ti_next    = '0;
        state_next = ST_BV_READ;
      end
      ST_BV_READ: state_next = ST_BV_P1X;
      ST_BV_P1X: begin
        cnt_next   = CW'(td - ti);
        state_next = ST_BV_PX;
      end
      ST_BV_CF: state_next = ST_BV_P1Y;
      ST_BV_P1Y: begin
        cnt_next   = CW'(ti);
        state_next = ST_BV_PY;
      end
      ST_BV_SP: state_next = ST_BV_ACC;
      ST_BV_ACC: begin
        if (ti == td) begin
          if (td == lim) begin
            state_next = ST_VAL;
          end else begin
            td_next    = td + TDW'(1);
            ti_next    = '0;
            state_next = ST_BV_READ;
          end
        end else begin
          ti_next    = ti + TDW'(1);
          state_next = ST_BV_READ;
        end
      end
      ST_VAL: begin
        // value written this cycle; divider set up next
        state_next = ST_DIV;
        sub_next   = SUB_DIV_INIT;
      end
      ST_DIV: begin
        case (sub)
          SUB_DIV_INIT: begin
            cnt_next = CW'(FRAC_BITS);
            sub_next = status.div_skip ? SUB_DONE : SUB_NONE;
          end
          SUB_NONE: begin
            cnt_next = cnt - CW'(1);
            sub_next = (cnt == CW'(1)) ? SUB_DONE : SUB_NONE;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    op   = OP_NONE;
    busy = (state != ST_IDLE);
    done = (state == ST_DIV) && (sub == SUB_DONE);
    case (state)
      ST_CENTRE:   op = OP_CENTRE;
      ST_SCALE_X:  op = OP_SCALE_X;
      ST_SCALE_Y:  op = OP_SCALE_Y;
      ST_SQ_X:     op = OP_SQ_X;
      ST_SQ_Y:     op = OP_SQ_Y;
      ST_COMB:     op = (status.mode == MODE_SADDLE) ? OP_SUB_SR : OP_ADD_SR;
      ST_BUMP_OMR: op = OP_ONE_MINUS_R;
      ST_BUMP_P1, ST_MONO_P1X, ST_MONO_P1Y, ST_BV_P1X, ST_BV_P1Y: op = OP_P_ONE;
      ST_BUMP_PW:  op = (cnt != '0) ? OP_P_MUL_R : OP_NONE;
      ST_MONO_PX, ST_BV_PX: op = (cnt != '0) ? OP_P_MUL_X : OP_NONE;
      ST_MONO_PY, ST_BV_PY: op = (cnt != '0) ? OP_P_MUL_Y : OP_NONE;
      ST_MONO_AMP: op = OP_S_AMP_P;
      ST_MK_XX:    op = OP_SQ_X;
      ST_MK_XXX:   op = OP_S_MUL_X;
      ST_MK_3X:    op = OP_R_3X;
      ST_MK_RY1, ST_MK_RY2: op = OP_R_MUL_Y;
      ST_MK_SUB:   op = OP_SUB_SR;
      ST_BV_CLR:   op = OP_ACC_CLR;
      ST_BV_READ:  op = OP_COEF_READ;
      ST_BV_CF:    op = OP_S_CF_P;
      ST_BV_SP:    op = OP_S_MUL_P;
      ST_BV_ACC:   op = OP_ACC_ADD;
      ST_VAL: begin
        if (sub == SUB_ZERO) begin
          op = OP_VAL_ZERO;
        end else begin
          case (status.mode)
            MODE_BUMP:  op = OP_VAL_AMP_P;
            MODE_MONO:  op = OP_VAL_S_P;
            MODE_BIVAR: op = OP_VAL_AMP_ACC;
            default:    op = OP_VAL_AMP_R;
          endcase
        end
      end
      ST_DIV: begin
        case (sub)
          SUB_DIV_INIT: op = OP_DIV_INIT;
          SUB_NONE:     op = OP_DIV_STEP;
          default:      op = OP_NONE;
        endcase
      end
      default: op = OP_NONE;
    endcase
  end

  `PFE_ASSERT(a_done_single, done |=> !done)
  `PFE_ASSERT(a_accept_busy, accept_eval |=> busy)
  `PFE_ASSERT(a_div_count, (state == ST_DIV && sub == SUB_NONE) |-> (cnt != '0))
  `PFE_ASSERT_ALWAYS(a_reset_idle, rst |=> (!busy && !done))

endmodule
